// ===== rtl/core/lmdw_pkg.sv =====
// Package: shared types, codes and the rotation function for the LED matrix delta writer.
package lmdw_pkg;

  localparam int unsigned MatrixSide = 8;
  localparam int unsigned CoordW     = $clog2(MatrixSide);
  localparam int unsigned OrientW    = 3;

  localparam logic [CoordW-1:0]  LastRow     = CoordW'(MatrixSide - 1);
  localparam logic [OrientW-1:0] OrientReset = 3'd1;

  // Orientation codes; anything else means no rotation
  localparam logic [OrientW-1:0] ORIENT_R180 = 3'd2;
  localparam logic [OrientW-1:0] ORIENT_QA   = 3'd3;
  localparam logic [OrientW-1:0] ORIENT_QB   = 3'd4;

  typedef enum logic [1:0] {
    FUNC_ROW   = 2'd0,
    FUNC_INVAL = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic {
    KIND_LED   = 1'b0,
    KIND_CLEAR = 1'b1
  } kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  // One accepted input transaction as seen by the core
  typedef struct packed {
    func_e                   func;
    logic [CoordW-1:0]       row;
    logic [MatrixSide-1:0]   bits;
  } cmd_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } coord_t;

  // Map picture coordinates to LED coordinates
  function automatic coord_t rotate(logic [OrientW-1:0] orient,
                                    logic [CoordW-1:0] x, logic [CoordW-1:0] y);
    coord_t r;
    unique case (orient)
      ORIENT_R180: begin r.x = LastRow - x; r.y = LastRow - y; end
      ORIENT_QA:   begin r.x = LastRow - y; r.y = x;           end
      ORIENT_QB:   begin r.x = y;           r.y = LastRow - x; end
      default:     begin r.x = x;           r.y = y;           end
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/lmdw_ifs.sv =====
// Interfaces: input row channel and output LED command channel.
interface lmdw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [2:0] row_index;
  logic [7:0] row_bits;

  modport source (output valid, func, row_index, row_bits, input ready);
  modport sink   (input valid, func, row_index, row_bits, output ready);
endinterface

interface lmdw_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [2:0] led_x;
  logic [2:0] led_y;
  logic       led_on;
  logic       last;

  modport source (output valid, kind, led_x, led_y, led_on, last, input ready);
  modport sink   (input valid, kind, led_x, led_y, led_on, last, output ready);
endinterface

// ===== rtl/core/lmdw_shadow.sv =====
// Shadow frame store and valid flag; produces the changed-pixel mask of a row.
module lmdw_shadow (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  lmdw_pkg::cmd_t                 cmd_i,
  output logic [lmdw_pkg::MatrixSide-1:0] changed_o
);
  import lmdw_pkg::*;

  logic [MatrixSide-1:0] rows_q [MatrixSide];
  logic                  valid_q;

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      unique case (cmd_i.func)
        FUNC_ROW:   if (cmd_i.row == LastRow) valid_q <= 1'b1;
        FUNC_INVAL: valid_q <= 1'b0;
        FUNC_CLEAR: valid_q <= 1'b1;
        default:    valid_q <= valid_q;
      endcase
    end
  end

  // Shadow rows, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      unique case (cmd_i.func)
        FUNC_ROW:   rows_q[cmd_i.row] <= cmd_i.bits;
        FUNC_CLEAR: rows_q <= '{default: '0};
        default: ;
      endcase
    end
  end

  // Everything counts as changed until the shadow is valid
  assign changed_o = valid_q ? (cmd_i.bits ^ rows_q[cmd_i.row]) : '1;

endmodule

// ===== rtl/core/lmdw_scan.sv =====
// Bit-serial scanner: shifts the changed mask out MSB first and fills the output register.
module lmdw_scan (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             load_i,
  input  lmdw_pkg::cmd_t                   cmd_i,
  input  logic [lmdw_pkg::MatrixSide-1:0]  changed_i,
  input  logic [lmdw_pkg::OrientW-1:0]     orient_i,
  input  logic                             out_ready_i,
  output logic                             in_ready_o,
  output logic                             out_valid_o,
  output logic                             kind_o,
  output logic [lmdw_pkg::CoordW-1:0]      led_x_o,
  output logic [lmdw_pkg::CoordW-1:0]      led_y_o,
  output logic                             led_on_o,
  output logic                             last_o
);
  import lmdw_pkg::*;

  state_e                state_q, state_d;
  logic [MatrixSide-1:0] chg_q, bits_q;
  logic [CoordW-1:0]     row_q, x_q;
  logic                  out_valid_q;
  kind_e                 kind_q;
  coord_t                pos_q;
  logic                  on_q, last_q;

  logic out_free, step, emit, rest_zero, start_scan, start_clear;
  coord_t pos_rot;

  assign out_free    = !out_valid_q || out_ready_i;
  assign rest_zero   = (chg_q[MatrixSide-2:0] == '0);
  assign start_scan  = load_i && (cmd_i.func == FUNC_ROW) && (changed_i != '0);
  assign start_clear = load_i && (cmd_i.func == FUNC_CLEAR);
  assign pos_rot     = rotate(orient_i, x_q, row_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_scan) state_d = ST_SCAN;
      ST_SCAN: if (step && rest_zero) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready_o = 1'b0;
    step       = 1'b0;
    emit       = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = out_free;
      ST_SCAN: begin
        step = !chg_q[MatrixSide-1] || out_free;
        emit = chg_q[MatrixSide-1] && out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit || start_clear) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Shift registers, one pixel per cycle; a changed pixel waits while the output register is full
  always_ff @(posedge clk_i) begin
    if (start_scan) begin
      chg_q  <= changed_i;
      bits_q <= cmd_i.bits;
      row_q  <= cmd_i.row;
      x_q    <= '0;
    end else if (step) begin
      chg_q  <= {chg_q[MatrixSide-2:0], 1'b0};
      bits_q <= {bits_q[MatrixSide-2:0], 1'b0};
      x_q    <= x_q + 1'b1;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q <= KIND_LED;
      pos_q  <= pos_rot;
      on_q   <= bits_q[MatrixSide-1];
      last_q <= rest_zero;
    end else if (start_clear) begin
      kind_q <= KIND_CLEAR;
      pos_q  <= '0;
      on_q   <= 1'b0;
      last_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign led_x_o     = pos_q.x;
  assign led_y_o     = pos_q.y;
  assign led_on_o    = on_q;
  assign last_o      = last_q;

endmodule

// ===== rtl/core/led_matrix_delta_writer.sv =====
// Top level: 8x8 LED matrix writer that sends only changed pixels.
// A bitmap row transaction is compared with a shadow copy of the frame, and each
// changed pixel leaves as one rotated LED write, leftmost pixel first, with the
// final write of the row flagged by last; until the shadow is valid (after row 7
// or a clear) every pixel is sent. A clear sends one clear-display command. A
// bitmap row is accepted and then scanned up to its last changed pixel by the scan
// shift register, one bit per cycle unless the output is stalled. The next
// transaction is accepted once the scan is done and the output register can take
// a result. Orientation may be written only while idle.
module led_matrix_delta_writer (
  input  logic             clk_i,
  input  logic             rst_ni,
  lmdw_in_if.sink          in_ch,
  lmdw_out_if.source       out_ch,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_data_i
);
  import lmdw_pkg::*;

  logic [OrientW-1:0]    orient_q;
  cmd_t                  cmd;
  logic                  load;
  logic [MatrixSide-1:0] changed;
  logic                  in_ready;

  // Orientation register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orient_q <= OrientReset;
    end else if (cfg_we_i) begin
      orient_q <= cfg_data_i;
    end
  end

  assign cmd.func = func_e'(in_ch.func);
  assign cmd.row  = in_ch.row_index;
  assign cmd.bits = in_ch.row_bits;

  assign in_ch.ready = in_ready;
  assign load        = in_ch.valid && in_ready;

  lmdw_shadow u_shadow (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load),
    .cmd_i     (cmd),
    .changed_o (changed)
  );

  lmdw_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .cmd_i       (cmd),
    .changed_i   (changed),
    .orient_i    (orient_q),
    .out_ready_i (out_ch.ready),
    .in_ready_o  (in_ready),
    .out_valid_o (out_ch.valid),
    .kind_o      (out_ch.kind),
    .led_x_o     (out_ch.led_x),
    .led_y_o     (out_ch.led_y),
    .led_on_o    (out_ch.led_on),
    .last_o      (out_ch.last)
  );

endmodule

// ===== test/led_matrix_delta_writer_test.sv =====
// Testbench for the LED matrix delta writer: predicts LED commands and checks them.
`timescale 1ns / 1ps

module led_matrix_delta_writer_test;
  import lmdw_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned DrainCycles   = 12;
  localparam int unsigned PhaseItems    = 34;

  // One expected LED command
  typedef struct {
    kind_e       kind;
    logic [2:0]  led_x;
    logic [2:0]  led_y;
    logic        led_on;
    logic        last;
  } led_cmd_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we;
  logic [2:0] cfg_data;

  lmdw_in_if  in_ch ();
  lmdw_out_if out_ch ();

  led_matrix_delta_writer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  // Stimulus backlog and predicted LED commands
  cmd_t        cmd_backlog[$];
  led_cmd_t    predicted_leds[$];

  // Predictor state: shadow frame, its valid flag, current orientation
  logic [7:0]  shadow_frame [8] = '{default: 8'h00};
  logic        frame_valid = 1'b0;
  logic [2:0]  orient = OrientReset;

  // Picture the stimulus believes is on the display, used to build small edits
  logic [7:0]  plan_frame [8] = '{default: 8'h00};

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_request = 1'b0;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  int unsigned errors = 0;
  int unsigned rows_accepted = 0;
  int unsigned leds_checked = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Rotate picture coordinates onto the LED matrix
  function automatic logic [5:0] orient_map(logic [2:0] x, logic [2:0] y);
    case (orient)
      ORIENT_R180: return {3'd7 - x, 3'd7 - y};
      ORIENT_QA:   return {3'd7 - y, x};
      ORIENT_QB:   return {y, 3'd7 - x};
      default:     return {x, y};
    endcase
  endfunction

  // Work out the LED commands caused by one accepted transaction
  function automatic void predict_led_writes(func_e f, logic [2:0] row, logic [7:0] bits);
    logic [7:0] changed;
    logic [7:0] mask;
    led_cmd_t   r;
    case (f)
      FUNC_INVAL: frame_valid = 1'b0;
      FUNC_CLEAR: begin
        foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
        frame_valid = 1'b1;
        r = '{kind: KIND_CLEAR, led_x: 3'd0, led_y: 3'd0, led_on: 1'b0, last: 1'b1};
        predicted_leds.push_back(r);
      end
      FUNC_ROW: begin
        changed = frame_valid ? (bits ^ shadow_frame[row]) : 8'hFF;
        for (int x = 0; x < 8; x++) begin
          mask = 8'h80 >> x;
          if ((changed & mask) != 8'h00) begin
            r.kind = KIND_LED;
            {r.led_x, r.led_y} = orient_map(3'(x), row);
            r.led_on = |(bits & mask);
            r.last = ((changed & (mask - 8'd1)) == 8'h00);
            predicted_leds.push_back(r);
          end
        end
        shadow_frame[row] = bits;
        if (row == LastRow) frame_valid = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: mismatch in %s: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Driver: offers backlog transactions, predicts on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid     <= 1'b0;
      in_ch.func      <= FUNC_ROW;
      in_ch.row_index <= '0;
      in_ch.row_bits  <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        predict_led_writes(func_e'(in_ch.func), in_ch.row_index, in_ch.row_bits);
        rows_accepted++;
      end
      if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cmd_t c;
        c = cmd_backlog.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.func      <= c.func;
        in_ch.row_index <= c.row;
        in_ch.row_bits  <= c.bits;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_request) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: takes LED commands and checks them in order
  always @(posedge clk_i or negedge rst_ni) begin
    led_cmd_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        leds_checked++;
        if (predicted_leds.size() == 0) begin
          errors++;
          $display("%0t: unexpected LED command: kind %0d x %0d y %0d on %0d last %0d",
                   $time, out_ch.kind, out_ch.led_x, out_ch.led_y, out_ch.led_on,
                   out_ch.last);
        end else begin
          want = predicted_leds.pop_front();
          compare_field("kind", want.kind, out_ch.kind);
          compare_field("led_x", want.led_x, out_ch.led_x);
          compare_field("led_y", want.led_y, out_ch.led_y);
          compare_field("led_on", want.led_on, out_ch.led_on);
          compare_field("last", want.last, out_ch.last);
        end
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: too long without any transaction on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: no progress for %0d cycles", $time, WatchdogLimit);
      $display("led_matrix_delta_writer_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_cmd(func_e f, logic [2:0] row, logic [7:0] bits);
    cmd_t c;
    c.func = f;
    c.row  = row;
    c.bits = bits;
    cmd_backlog.push_back(c);
    if (f == FUNC_ROW) plan_frame[row] = bits;
    if (f == FUNC_CLEAR) foreach (plan_frame[i]) plan_frame[i] = 8'h00;
  endtask

  // Mostly frame edits and full redraws, some clears, invalidates and junk
  task automatic queue_random_cmds(int unsigned count);
    int unsigned made;
    int unsigned pick;
    logic [2:0]  row;
    logic [7:0]  flips;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(99);
      row  = 3'($urandom_range(7));
      if (pick < 45) begin
        flips = 8'($urandom_range(255)) & 8'($urandom_range(255));
        queue_cmd(FUNC_ROW, row, plan_frame[row] ^ flips);
        made++;
      end else if (pick < 60) begin
        if (pick < 52) begin
          queue_cmd(FUNC_INVAL, row, 8'($urandom_range(255)));
          made++;
        end
        for (int r = 0; r < 8; r++) queue_cmd(FUNC_ROW, 3'(r), 8'($urandom_range(255)));
        made += 8;
      end else if (pick < 70) begin
        queue_cmd(FUNC_CLEAR, row, 8'($urandom_range(255)));
        made++;
      end else if (pick < 77) begin
        queue_cmd(FUNC_INVAL, row, 8'($urandom_range(255)));
        made++;
      end else if (pick < 82) begin
        queue_cmd(FUNC_NONE, row, 8'($urandom_range(255)));
      end else begin
        queue_cmd(FUNC_ROW, row, 8'($urandom_range(255)));
        made++;
      end
    end
  endtask

  // Everything accepted, everything answered, scan given time to finish
  task automatic wait_until_idle();
    while (cmd_backlog.size() != 0 || in_ch.valid || predicted_leds.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_orientation(logic [2:0] value);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    orient = value;
    @(negedge clk_i);
  endtask

  task automatic run_phase(logic [2:0] orientation, int unsigned idle_pct,
                           int unsigned stall_pct, bit with_hold);
    write_orientation(orientation);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if (with_hold) hold_request = 1'b1;
    queue_random_cmds(PhaseItems);
    // Request seen at exactly one rising edge
    @(negedge clk_i);
    hold_request = 1'b0;
    wait_until_idle();
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_data        = 3'd0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: first a full frame while the shadow is invalid, so every
    // shadow row is written before any compare reads it
    queue_cmd(FUNC_ROW, 3'd0, 8'h00);
    queue_cmd(FUNC_ROW, 3'd1, 8'hFF);
    queue_cmd(FUNC_ROW, 3'd2, 8'h80);
    queue_cmd(FUNC_ROW, 3'd3, 8'h01);
    queue_cmd(FUNC_ROW, 3'd4, 8'hA5);
    queue_cmd(FUNC_ROW, 3'd5, 8'h5A);
    queue_cmd(FUNC_ROW, 3'd6, 8'h3C);
    queue_cmd(FUNC_ROW, 3'd7, 8'hC3);
    queue_cmd(FUNC_ROW, 3'd4, 8'hA5);   // unchanged row, nothing sent
    queue_cmd(FUNC_ROW, 3'd0, 8'h80);   // only the leftmost pixel
    queue_cmd(FUNC_ROW, 3'd1, 8'hFE);   // only the rightmost pixel
    queue_cmd(FUNC_ROW, 3'd7, 8'h00);
    queue_cmd(FUNC_NONE, 3'd5, 8'hFF);  // unused code, ignored
    queue_cmd(FUNC_INVAL, 3'd0, 8'h00);
    queue_cmd(FUNC_ROW, 3'd3, 8'h01);   // same bits but shadow invalid
    queue_cmd(FUNC_ROW, 3'd7, 8'h00);   // out of order row 7 sets the flag
    queue_cmd(FUNC_ROW, 3'd2, 8'h80);
    queue_cmd(FUNC_CLEAR, 3'd7, 8'hFF);
    queue_cmd(FUNC_ROW, 3'd6, 8'hFF);
    queue_cmd(FUNC_ROW, 3'd5, 8'h00);
    queue_cmd(FUNC_CLEAR, 3'd0, 8'h00); // clear while row 6 is lit
    queue_cmd(FUNC_INVAL, 3'd2, 8'h55);
    queue_cmd(FUNC_ROW, 3'd7, 8'h00);
    wait_until_idle();

    // Random phases over orientations and idle patterns
    run_phase(3'd2, 0, 0, 1'b0);
    run_phase(3'd3, 67, 0, 1'b0);
    run_phase(3'd4, 0, 67, 1'b0);
    run_phase(3'd0, 15, 15, 1'b0);
    run_phase(3'd7, 0, 0, 1'b1);
    run_phase(3'd5, 67, 0, 1'b0);

    $display("Covered %0d input transactions and %0d LED commands", rows_accepted,
             leds_checked);
    $display("across orientations 0, 1, 2, 3, 4, 5 and 7 with idle, stall and hold-off");
    if (errors == 0) begin
      $display("led_matrix_delta_writer_test: done, clean");
    end else begin
      $display("led_matrix_delta_writer_test: done, errors");
    end
    $finish;
  end

endmodule
